// ===== hdl/fcdma_pkg.sv =====
`timescale 1ns / 1ps
package fcdma_pkg;
    localparam int CHANNELS = 4;
    localparam int CH_W = $clog2(CHANNELS) > 0 ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    localparam logic [2:0] REG_SRC = 3'd0;
    localparam logic [2:0] REG_DST = 3'd1;
    localparam logic [2:0] REG_TOTAL = 3'd2;
    localparam logic [2:0] REG_BLOCK = 3'd3;
    localparam logic [2:0] REG_FILL = 3'd4;
    localparam logic [2:0] REG_CTRL = 3'd5;

    localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFC;
    localparam logic [31:0] TOTAL_MASK = 32'h0FFF_FFFF;
    localparam logic [31:0] BLOCK_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] CTRL_MASK = 32'hFF0F_FFFF;
    localparam logic [31:0] FILL_BASE = 32'h0400_4118;
    localparam logic [31:0] FILL_STRIDE = 32'h0000_001C;
    localparam logic [24:0] BLOCK_MAX = 25'h100_0000;

    typedef struct packed {
        logic [4:0] request_type;
        logic [31:0] write_value;
        logic [31:0] write_mask;
        logic [2:0] reg_select;
        logic [1:0] channel;
        logic [1:0] command;
    } t_item;

    typedef struct packed {
        logic step_error;
        logic [3:0] pending_mask;
        logic start_request;
        logic [1:0] irq_channel;
        logic irq_valid;
        logic [31:0] fill_value;
        logic use_fill;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic move_valid;
    } t_result;
endpackage

// ===== hdl/fcdma_queue.sv =====
`timescale 1ns / 1ps
module fcdma_queue
    import fcdma_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && o_ready) r_wp <= ~r_wp;
            if (i_pop && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && o_ready) - 2'(i_pop && o_valid);
        end
    end
endmodule

// ===== hdl/fcdma_engine.sv =====
`timescale 1ns / 1ps
module fcdma_engine
    import fcdma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);
    logic [31:0] r_ssrc [CHANNELS];
    logic [31:0] r_sdst [CHANNELS];
    logic [31:0] r_wsrc [CHANNELS];
    logic [31:0] r_wdst [CHANNELS];
    logic [27:0] r_total [CHANNELS];
    logic [23:0] r_bsize [CHANNELS];
    logic [31:0] r_fill [CHANNELS];
    logic [31:0] r_ctrl [CHANNELS];
    logic [CHANNELS-1:0] r_queued;
    logic [24:0] r_bleft;
    logic r_active;
    logic [CH_W-1:0] r_served;
    logic r_ovalid;
    t_result r_res;

    logic take;
    logic [CH_W-1:0] ch, c, low;
    logic ch_ok, found;
    logic [31:0] cw, old_cw, new_cw, m, ws, wd, fs;
    logic [CHANNELS-1:0] hit, q_after;
    logic [4:0] rtype;
    logic do_req, restart, done, term, clr_en;
    logic [1:0] dmode, smode;
    logic [24:0] bl_start, bl_next;
    logic [27:0] tot_next;
    t_result res;

    assign take = i_valid && (!r_ovalid || i_ready);
    assign o_pop = take;
    assign o_valid = r_ovalid;
    assign o_result = r_res;
    assign ch = i_item.channel[CH_W-1:0];
    assign ch_ok = ({30'd0, i_item.channel} < CHANNELS);

    always_comb begin
        old_cw = r_ctrl[ch];
        m = i_item.write_mask & CTRL_MASK;
        new_cw = (old_cw & ~m) | (i_item.write_value & m);
        low = '0;
        found = 1'b0;
        for (int k = CHANNELS - 1; k >= 0; k--) begin
            if (r_queued[k]) begin
                low = CH_W'(k);
                found = 1'b1;
            end
        end
        restart = !r_active || !r_queued[r_served];
        c = restart ? low : r_served;
        bl_start = (r_bsize[c] != 24'd0) ? {1'b0, r_bsize[c]} : BLOCK_MAX;
        cw = r_ctrl[c];
        dmode = cw[11:10];
        smode = cw[14:13];
        fs = FILL_BASE + FILL_STRIDE * 32'(c);
        ws = (smode == 2'd3) ? fs : r_wsrc[c];
        wd = r_wdst[c];
        bl_next = (restart ? bl_start : r_bleft) - 25'd1;
        tot_next = r_total[c] - 28'd1;
        term = 1'b0;
        clr_en = 1'b0;
        done = 1'b0;
        if (cw[29:28] != 2'b00) begin
            done = (bl_next == 25'd0);
            term = done;
            clr_en = done && cw[28];
        end else begin
            term = (tot_next == 28'd0);
            clr_en = term;
            done = term || (bl_next == 25'd0);
        end
        do_req = 1'b0;
        rtype = i_item.request_type;
        if (i_item.command == CMD_REQUEST) begin
            do_req = 1'b1;
        end else if (i_item.command == CMD_WRITE && ch_ok && i_item.reg_select == REG_CTRL
                     && !old_cw[31] && new_cw[31] && new_cw[28]) begin
            do_req = 1'b1;
            rtype = new_cw[28:24];
        end
        for (int k = 0; k < CHANNELS; k++) begin
            if (i_item.command == CMD_WRITE && ch == CH_W'(k)) begin
                hit[k] = new_cw[31] && new_cw[28:24] == rtype;
            end else begin
                hit[k] = r_ctrl[k][31] && r_ctrl[k][28:24] == rtype;
            end
        end
        res = '0;
        q_after = r_queued;
        if (do_req) begin
            q_after = r_queued | hit;
            res.start_request = (r_queued == '0) && (q_after != '0);
        end else if (i_item.command == CMD_STEP && found) begin
            if (dmode == 2'd3) begin
                res.step_error = 1'b1;
                q_after[c] = 1'b0;
            end else begin
                res.move_valid = 1'b1;
                res.source_address = ws;
                res.dest_address = wd;
                res.use_fill = (smode == 2'd3);
                res.fill_value = (smode == 2'd3) ? r_fill[c] : 32'd0;
                res.irq_valid = term && cw[30];
                res.irq_channel = (term && cw[30]) ? 2'(c) : 2'd0;
                if (done) q_after[c] = 1'b0;
            end
        end
        res.pending_mask = 4'(q_after);
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_queued <= '0;
            r_bleft <= '0;
            r_active <= 1'b0;
            r_served <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_ssrc[k] <= '0;
                r_sdst[k] <= '0;
                r_wsrc[k] <= '0;
                r_wdst[k] <= '0;
                r_total[k] <= '0;
                r_bsize[k] <= '0;
                r_fill[k] <= '0;
                r_ctrl[k] <= '0;
            end
        end else begin
            if (take) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (take) begin
                r_queued <= q_after;
                if (i_item.command == CMD_WRITE && ch_ok) begin
                    case (i_item.reg_select)
                        REG_SRC: r_ssrc[ch] <= (r_ssrc[ch] & ~(i_item.write_mask & ADDR_MASK))
                            | (i_item.write_value & i_item.write_mask & ADDR_MASK);
                        REG_DST: r_sdst[ch] <= (r_sdst[ch] & ~(i_item.write_mask & ADDR_MASK))
                            | (i_item.write_value & i_item.write_mask & ADDR_MASK);
                        REG_TOTAL: r_total[ch] <= (r_total[ch] & ~i_item.write_mask[27:0])
                            | (i_item.write_value[27:0] & i_item.write_mask[27:0]);
                        REG_BLOCK: r_bsize[ch] <= (r_bsize[ch] & ~i_item.write_mask[23:0])
                            | (i_item.write_value[23:0] & i_item.write_mask[23:0]);
                        REG_FILL: r_fill[ch] <= (r_fill[ch] & ~i_item.write_mask)
                            | (i_item.write_value & i_item.write_mask);
                        REG_CTRL: begin
                            r_ctrl[ch] <= new_cw;
                            if (!old_cw[31] && new_cw[31]) begin
                                r_wsrc[ch] <= r_ssrc[ch];
                                r_wdst[ch] <= r_sdst[ch];
                            end
                        end
                        default: ;
                    endcase
                end else if (i_item.command == CMD_STEP && found) begin
                    r_served <= c;
                    if (dmode == 2'd3) begin
                        r_active <= 1'b0;
                        r_bleft <= '0;
                    end else begin
                        if (cw[29:28] == 2'b00) r_total[c] <= tot_next;
                        if (clr_en) r_ctrl[c][31] <= 1'b0;
                        if (done && cw[15]) r_wsrc[c] <= r_ssrc[c];
                        else if (smode == 2'd0) r_wsrc[c] <= ws + 32'd4;
                        else if (smode == 2'd1) r_wsrc[c] <= ws - 32'd4;
                        else r_wsrc[c] <= ws;
                        if (done && cw[12]) r_wdst[c] <= r_sdst[c];
                        else if (dmode == 2'd0) r_wdst[c] <= wd + 32'd4;
                        else if (dmode == 2'd1) r_wdst[c] <= wd - 32'd4;
                        r_active <= !done;
                        r_bleft <= done ? 25'd0 : bl_next;
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_irq_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.irq_valid |-> r_res.move_valid) else $error("irq without move");
    a_err_nomove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.step_error |-> !r_res.move_valid) else $error("error with move");
    a_fill_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_res.use_fill |-> r_res.fill_value == 32'd0) else $error("fill leak");
`endif
endmodule

// ===== hdl/four_channel_dma_controller.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Contents
// s_axis  | in        | tdata: command, channel, reg_select, write_mask, write_value, request_type
// m_axis  | out       | tdata: move_valid .. step_error, tuser: none
// One transaction per cycle while m_axis_tready is high; the engine result is registered.
// A two-entry queue separates input acceptance from the engine.
// Reset is synchronous, active low, and clears all channel registers.
// An output stall holds the result register and lets the queue fill.
module four_channel_dma_controller
    import fcdma_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], channel[3:2], reg_select[6:4], write_mask[38:7],
    // write_value[70:39], request_type[75:71]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // move_valid[0], source_address[32:1], dest_address[64:33], use_fill[65],
    // fill_value[97:66], irq_valid[98], irq_channel[100:99], start_request[101],
    // pending_mask[105:102], step_error[106]
    output logic [111:0] m_axis_tdata
);
    t_item in_item, q_item;
    logic q_valid, q_pop;
    t_result res;

    assign in_item = s_axis_tdata[75:0];

    fcdma_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid), .i_item(in_item), .o_ready(s_axis_tready),
        .i_pop(q_pop), .o_valid(q_valid), .o_item(q_item)
    );

    fcdma_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_item(q_item), .o_pop(q_pop),
        .o_valid(m_axis_tvalid), .o_result(res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, res};
endmodule
